### src/lcfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcfs_pkg
// Sizes, memory layout and fixed-point helpers for the LSTM cell step.
// ----------------------------------------------------------------------------
package lcfs_pkg;

  localparam int HiddenUnits = 32;
  localparam int InputUnits  = 2;
  localparam int GateWords   = InputUnits * HiddenUnits + HiddenUnits * HiddenUnits;
  localparam int WeightDepth = 4 * GateWords + HiddenUnits;
  localparam int AddrW       = $clog2(WeightDepth);
  localparam int HidxW       = (HiddenUnits > 1) ? $clog2(HiddenUnits) : 1;
  localparam int Terms       = InputUnits + HiddenUnits;
  localparam int CntW        = $clog2(Terms + 1);
  localparam int AccW        = 32 + $clog2(Terms) + 1;

  localparam logic [1:0] GateIn   = 2'd0;
  localparam logic [1:0] GateFgt  = 2'd1;
  localparam logic [1:0] GateOut  = 2'd2;
  localparam logic [1:0] GateCand = 2'd3;

  typedef logic [12:0] prob_t;

  function automatic logic signed [15:0] narrow(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] t;
    logic signed [AccW-1:0] q;
    t = v + AccW'(2048);
    q = t >>> 12;
    if (q > 32767) return 16'sh7fff;
    else if (q < -32768) return 16'sh8000;
    else return q[15:0];
  endfunction

  function automatic prob_t sigm(input logic signed [15:0] x);
    logic [16:0] a;
    prob_t y;
    a = x[15] ? (17'd0 - {x[15], x}) : {1'b0, x};
    if (a >= 17'd20480) y = 13'd4096;
    else if (a >= 17'd9728) y = 13'(a >> 5) + 13'd3456;
    else if (a >= 17'd4096) y = 13'(a >> 3) + 13'd2560;
    else y = 13'(a >> 2) + 13'd2048;
    return x[15] ? (13'd4096 - y) : y;
  endfunction

  function automatic logic signed [13:0] tanh_q(input logic signed [15:0] x);
    logic signed [16:0] d;
    logic signed [15:0] s;
    logic signed [14:0] r;
    d = {x, 1'b0};
    if (d > 17'sd32767) s = 16'sh7fff;
    else if (d < -17'sd32768) s = 16'sh8000;
    else s = d[15:0];
    r = $signed({1'b0, sigm(s), 1'b0}) - 15'sd4096;
    return r[13:0];
  endfunction

endpackage
`default_nettype wire

### src/lcfs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcfs_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lcfs_ram #(
  parameter int Depth = 4384,
  parameter int Width = 16,
  localparam int AW   = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

### src/lstm_cell_forward_step.sv
// A time step is paced by the single MAC fed from the one read port of the
// weight memory, one weight per cycle while a sum is issued, with the MAC
// drained before each activation.
// Throughput: one transaction at a time; writes are taken every cycle while idle.
// Reset clears hidden and cell state and control; weights stay undefined.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lstm_cell_forward_step
// LSTM cell time step with sigmoid output unit, Q4.12, sequential MAC.
// ----------------------------------------------------------------------------
module lstm_cell_forward_step (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               req_type_i,
  input  wire logic        [12:0] weight_index_i,
  input  wire logic signed [15:0] weight_value_i,
  input  wire logic signed [15:0] input_a_i,
  input  wire logic signed [15:0] input_b_i,
  input  wire logic               seq_start_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic             [12:0] out_prob_o,
  output logic                    out_bit_o
);

  localparam int H  = lcfs_pkg::HiddenUnits;
  localparam int AW = lcfs_pkg::AddrW;
  localparam int HW = lcfs_pkg::HidxW;
  localparam int CW = lcfs_pkg::CntW;
  localparam int AC = lcfs_pkg::AccW;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StIssue = 4'd1;
  localparam logic [3:0] StDrain = 4'd2;
  localparam logic [3:0] StAct   = 4'd3;
  localparam logic [3:0] StC1    = 4'd4;
  localparam logic [3:0] StC2    = 4'd5;
  localparam logic [3:0] StC3    = 4'd6;
  localparam logic [3:0] StT1    = 4'd7;
  localparam logic [3:0] StH1    = 4'd8;
  localparam logic [3:0] StH2    = 4'd9;
  localparam logic [3:0] StFin   = 4'd10;

  logic [3:0] state_q;
  logic [HW-1:0] j_q;
  logic [1:0] k_q;
  logic odot_q;
  logic [CW-1:0] cnt_q;
  logic [AW-1:0] addr_q;
  logic v1_q, v2_q;
  logic signed [15:0] opnd_q;
  logic signed [31:0] prod_q;
  logic signed [AC-1:0] acc_q;
  logic signed [15:0] xa_q, xb_q;
  logic signed [15:0] hid_q [H];
  logic signed [15:0] hnx_q [H];
  logic signed [15:0] cell_q [H];
  lcfs_pkg::prob_t act_q [4];
  logic signed [31:0] p1_q, p2_q;
  logic signed [13:0] t_q;
  logic [15:0] rd_data;
  logic mem_we, mem_re;
  logic signed [15:0] opnd_d;
  logic [CW-1:0] last_cnt;
  lcfs_pkg::prob_t act_now;
  logic [CW-1:0] hidx_c;

  assign in_ready_o = (state_q == StIdle);
  assign mem_we = in_valid_i && in_ready_o && !req_type_i &&
                  (weight_index_i < 13'(lcfs_pkg::WeightDepth));
  assign mem_re = (state_q == StIssue);
  assign last_cnt = odot_q ? CW'(H - 1) : CW'(lcfs_pkg::Terms - 1);
  assign act_now = lcfs_pkg::sigm(lcfs_pkg::narrow(acc_q));
  assign hidx_c = cnt_q - CW'(lcfs_pkg::InputUnits);

  lcfs_ram #(
    .Depth(lcfs_pkg::WeightDepth),
    .Width(16)
  ) u_wmem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(weight_index_i[AW-1:0]),
    .wdata_i(weight_value_i),
    .re_i   (mem_re),
    .raddr_i(addr_q),
    .rdata_o(rd_data)
  );

  always_comb begin
    if (odot_q) begin
      opnd_d = hnx_q[cnt_q[HW-1:0]];
    end else if (cnt_q == CW'(0)) begin
      opnd_d = xa_q;
    end else if (cnt_q == CW'(1)) begin
      opnd_d = xb_q;
    end else begin
      opnd_d = hid_q[hidx_c[HW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q <= opnd_d;
    prod_q <= $signed(rd_data) * opnd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      j_q         <= '0;
      k_q         <= '0;
      odot_q      <= 1'b0;
      cnt_q       <= '0;
      addr_q      <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      acc_q       <= '0;
      out_valid_o <= 1'b0;
      out_prob_o  <= '0;
      out_bit_o   <= 1'b0;
      for (int i = 0; i < H; i++) begin
        hid_q[i]  <= '0;
        hnx_q[i]  <= '0;
        cell_q[i] <= '0;
      end
    end else begin
      v1_q <= mem_re;
      v2_q <= v1_q;
      if (v2_q) acc_q <= acc_q + AC'(prod_q);
      if (out_valid_o && out_ready_i && (state_q != StFin)) out_valid_o <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_valid_i && req_type_i) begin
            xa_q   <= input_a_i;
            xb_q   <= input_b_i;
            j_q    <= '0;
            k_q    <= lcfs_pkg::GateIn;
            odot_q <= 1'b0;
            cnt_q  <= '0;
            acc_q  <= '0;
            addr_q <= '0;
            if (seq_start_i) begin
              for (int i = 0; i < H; i++) begin
                hid_q[i]  <= '0;
                hnx_q[i]  <= '0;
                cell_q[i] <= '0;
              end
            end
            state_q <= StIssue;
          end
        end
        StIssue: begin
          cnt_q  <= cnt_q + CW'(1);
          addr_q <= odot_q ? addr_q + AW'(1) : addr_q + AW'(H);
          if (cnt_q == last_cnt) state_q <= StDrain;
        end
        StDrain: begin
          if (!v1_q && !v2_q) state_q <= StAct;
        end
        StAct: begin
          if (odot_q) begin
            state_q <= StFin;
          end else begin
            act_q[k_q] <= act_now;
            if (k_q == lcfs_pkg::GateCand) begin
              state_q <= StC1;
            end else begin
              k_q     <= k_q + 2'd1;
              cnt_q   <= '0;
              acc_q   <= '0;
              addr_q  <= AW'(32'(k_q + 2'd1) * lcfs_pkg::GateWords + 32'(j_q));
              state_q <= StIssue;
            end
          end
        end
        StC1: begin
          p1_q    <= 32'($signed({1'b0, act_q[lcfs_pkg::GateFgt]}) * cell_q[j_q]);
          state_q <= StC2;
        end
        StC2: begin
          p2_q    <= $signed(32'(act_q[lcfs_pkg::GateCand]) * 32'(act_q[lcfs_pkg::GateIn]));
          state_q <= StC3;
        end
        StC3: begin
          cell_q[j_q] <= lcfs_pkg::narrow(AC'(p1_q) + AC'(p2_q));
          state_q     <= StT1;
        end
        StT1: begin
          t_q     <= lcfs_pkg::tanh_q(cell_q[j_q]);
          state_q <= StH1;
        end
        StH1: begin
          p1_q    <= 32'($signed({1'b0, act_q[lcfs_pkg::GateOut]}) * t_q);
          state_q <= StH2;
        end
        StH2: begin
          hnx_q[j_q] <= lcfs_pkg::narrow(AC'(p1_q));
          cnt_q      <= '0;
          acc_q      <= '0;
          k_q        <= lcfs_pkg::GateIn;
          if (j_q == HW'(H - 1)) begin
            odot_q <= 1'b1;
            addr_q <= AW'(4 * lcfs_pkg::GateWords);
          end else begin
            j_q    <= j_q + HW'(1);
            addr_q <= AW'(32'(j_q) + 1);
          end
          state_q <= StIssue;
        end
        StFin: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o <= 1'b1;
            out_prob_o  <= act_now;
            out_bit_o   <= (act_now >= 13'd2048);
            for (int i = 0; i < H; i++) hid_q[i] <= hnx_q[i];
            odot_q  <= 1'b0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_mac_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(v1_q)) else $error("MAC stage without a read");
  a_read_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> $past(state_q == StIssue)) else $error("read outside issue");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == StFin)) else $error("stray result");
  a_act_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StAct) |-> (!v1_q && !v2_q)) else $error("activation before drain");
`endif

endmodule
`default_nettype wire

### tb/lstm_cell_forward_step_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstm_cell_forward_step_test
// Loads the full weight memory, then runs directed and random weight writes
// and time steps under several idle/stall mixes; every output transaction
// is checked against a cycle-free model of the Q4.12 LSTM step.
// ----------------------------------------------------------------------------
module lstm_cell_forward_step_test;

  localparam int WatchdogLimit = 20000;

  class lstm_scoreboard;
    int     wmem[lcfs_pkg::WeightDepth];
    int     hid[lcfs_pkg::HiddenUnits];
    int     cst[lcfs_pkg::HiddenUnits];
    int     exp_prob[$];
    bit     exp_bit[$];
    int     errors;

    function int sat_q(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
    endfunction

    function int round_q(longint v);
      longint t;
      t = (v + 2048) >>> 12;
      return sat_q(t);
    endfunction

    function int squash(int x);
      int a;
      int y;
      a = (x < 0) ? -x : x;
      if (a >= 20480) y = 4096;
      else if (a >= 9728) y = (a >> 5) + 3456;
      else if (a >= 4096) y = (a >> 3) + 2560;
      else y = (a >> 2) + 2048;
      return (x < 0) ? 4096 - y : y;
    endfunction

    function int tanh_fx(int x);
      return 2 * squash(sat_q(2 * longint'(x))) - 4096;
    endfunction

    function void note_input(bit rt, int idx, int wv, int a, int b, bit ss);
      int     act[4];
      int     hnew[lcfs_pkg::HiddenUnits];
      longint acc;
      int     base;
      int     p;
      if (!rt) begin
        if (idx < lcfs_pkg::WeightDepth) wmem[idx] = wv;
        return;
      end
      if (ss) begin
        foreach (hid[i]) begin
          hid[i] = 0;
          cst[i] = 0;
        end
      end
      for (int j = 0; j < lcfs_pkg::HiddenUnits; j++) begin
        for (int k = 0; k < 4; k++) begin
          base = k * lcfs_pkg::GateWords;
          acc = longint'(a) * wmem[base + j] +
                longint'(b) * wmem[base + lcfs_pkg::HiddenUnits + j];
          base += lcfs_pkg::InputUnits * lcfs_pkg::HiddenUnits;
          for (int m = 0; m < lcfs_pkg::HiddenUnits; m++)
            acc += longint'(hid[m]) * wmem[base + m * lcfs_pkg::HiddenUnits + j];
          act[k] = squash(round_q(acc));
        end
        cst[j] = round_q(longint'(act[lcfs_pkg::GateFgt]) * cst[j] +
                         longint'(act[lcfs_pkg::GateCand]) * act[lcfs_pkg::GateIn]);
        hnew[j] = round_q(longint'(act[lcfs_pkg::GateOut]) * tanh_fx(cst[j]));
      end
      acc = 0;
      for (int j = 0; j < lcfs_pkg::HiddenUnits; j++)
        acc += longint'(hnew[j]) * wmem[4 * lcfs_pkg::GateWords + j];
      hid = hnew;
      p = squash(round_q(acc));
      exp_prob = {exp_prob, p};
      exp_bit = {exp_bit, bit'(p >= 2048)};
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(int prob, bit ob);
      int ep;
      bit eb;
      if (exp_prob.size() == 0) begin
        report("output transaction with nothing expected");
        return;
      end
      ep = exp_prob.pop_front();
      eb = exp_bit.pop_front();
      if (prob != ep) report($sformatf("out_prob %0d, expected %0d", prob, ep));
      if (ob != eb) report($sformatf("out_bit %0d, expected %0d", ob, eb));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               req_type_i;
  logic        [12:0] weight_index_i;
  logic signed [15:0] weight_value_i;
  logic signed [15:0] input_a_i;
  logic signed [15:0] input_b_i;
  logic               seq_start_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic        [12:0] out_prob_o;
  logic               out_bit_o;

  lstm_scoreboard sb = new();
  int idle_in;
  int stall_out;
  int quiet_cycles;

  lstm_cell_forward_step dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles = quiet_cycles + 1;
      if (in_valid_i && in_ready_o) begin
        sb.note_input(req_type_i, weight_index_i, weight_value_i, input_a_i,
                      input_b_i, seq_start_i);
        quiet_cycles = 0;
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_result(out_prob_o, out_bit_o);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no transaction in %0d cycles", WatchdogLimit);
        $display("** lstm_cell_forward_step: FAILED **");
        $finish;
      end
      out_ready_i <= ($urandom_range(99) >= stall_out);
    end
  end

  task send_txn(bit rt, int idx, int wv, int a, int b, bit ss);
    if ($urandom_range(99) < idle_in) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= rt;
    weight_index_i <= idx[12:0];
    weight_value_i <= wv[15:0];
    input_a_i      <= a[15:0];
    input_b_i      <= b[15:0];
    seq_start_i    <= ss;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task write_w(int idx, int wv);
    send_txn(1'b0, idx, wv, $urandom, $urandom, $urandom_range(1));
  endtask

  task run_step(int a, int b, bit ss);
    send_txn(1'b1, $urandom, $urandom, a, b, ss);
  endtask

  function int rand_weight();
    if ($urandom_range(9) < 7) return $signed(13'($urandom)) / 4;
    return $signed(16'($urandom));
  endfunction

  task drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.exp_prob.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    in_valid_i     <= 1'b0;
    req_type_i     <= 1'b0;
    weight_index_i <= '0;
    weight_value_i <= '0;
    input_a_i      <= '0;
    input_b_i      <= '0;
    seq_start_i    <= 1'b0;
    out_ready_i    <= 1'b0;
    idle_in        = 0;
    stall_out      = 0;
    quiet_cycles   = 0;
    rst_ni         = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < lcfs_pkg::WeightDepth; i++) write_w(i, rand_weight());

    // directed: extremes, sequence starts, saturation, ignored writes
    run_step(0, 0, 1'b1);
    run_step(32767, 32767, 1'b0);
    run_step(-32768, -32768, 1'b0);
    run_step(32767, -32768, 1'b1);
    write_w(lcfs_pkg::WeightDepth, 32767);
    write_w(8191, -32768);
    write_w(lcfs_pkg::WeightDepth - 1, 32767);
    write_w(0, -32768);
    write_w(lcfs_pkg::HiddenUnits, 32767);
    write_w(lcfs_pkg::GateWords, 32767);
    run_step(-32768, 32767, 1'b0);
    run_step(32767, 32767, 1'b0);
    write_w(lcfs_pkg::WeightDepth - 1, -32768);
    run_step(32767, 0, 1'b0);
    run_step(0, -32768, 1'b1);
    run_step(1, -1, 1'b0);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_in = 0;  stall_out = 0;  end
        1: begin idle_in = 46; stall_out = 0;  end
        2: begin idle_in = 0;  stall_out = 46; end
        default: begin idle_in = 27; stall_out = 27; end
      endcase
      for (int n = 0; n < 125; n++) begin
        if (p == 1 && n == 60) drain();
        if ($urandom_range(99) < 25)
          run_step($urandom, $urandom, $urandom_range(99) < 20);
        else if ($urandom_range(9) == 0)
          write_w($urandom_range(8191, lcfs_pkg::WeightDepth), $urandom);
        else
          write_w($urandom_range(lcfs_pkg::WeightDepth - 1), rand_weight());
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.exp_prob.size() == 0) begin
      $display("** lstm_cell_forward_step: PASSED **");
    end else begin
      $display("** lstm_cell_forward_step: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
src/lcfs_pkg.sv
src/lcfs_ram.sv
src/lstm_cell_forward_step.sv
tb/lstm_cell_forward_step_test.sv
